// File: rtl/sprm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sprm_pkg: shared types and helpers
// Widths, item codes, queue entry layout and comparison helpers for the
// sparse-table range-maximum unit.
// ---------------------------------------------------------------------------
package sprm_pkg;

    localparam int MAX_LENGTH = 1024;
    localparam int LEVELS     = 11;
    localparam int VALUE_W    = 32;

    localparam int IDX_W      = $clog2(MAX_LENGTH);
    localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
    localparam int LEVEL_W    = $clog2(LEVELS);
    localparam int ADDR_W     = LEVEL_W + IDX_W;
    localparam int DEPTH      = LEVELS * MAX_LENGTH;
    localparam int STATUS_W   = 2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        K_LOAD,
        K_LOAD_BAD,
        K_QUERY,
        K_QUERY_BAD
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic                       last;
        logic [LEVEL_W-1:0]         lvl;
        logic [IDX_W-1:0]           left;
        logic [IDX_W-1:0]           second;
        logic signed [VALUE_W-1:0]  value;
    } item_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_BUILD,
        BK_GAP
    } bk_state_t;

    function automatic logic [LEVEL_W-1:0] floor_log2(input logic [LEN_W-1:0] x);
        logic [LEVEL_W-1:0] k;
        k = '0;
        for (int b = 1; b < LEN_W; b++)
        begin
            if (x[b])
            begin
                k = LEVEL_W'(b);
            end
        end
        if (k > LEVEL_W'(LEVELS - 1))
        begin
            k = LEVEL_W'(LEVELS - 1);
        end
        return k;
    endfunction

    function automatic logic signed [VALUE_W-1:0] smax(input logic signed [VALUE_W-1:0] a,
                                                       input logic signed [VALUE_W-1:0] b);
        return (a >= b) ? a : b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/sprm_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sprm_ram: generic memory
// One write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module sprm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

// File: rtl/sprm_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sprm_front: request classifier
// Checks load positions and query ranges and works out the window level
// and second window start for each query.
// ---------------------------------------------------------------------------
module sprm_front
    import sprm_pkg::*;
(
    input  wire logic                      start,
    input  wire logic                      full,
    input  wire logic                      req_type,
    input  wire logic [IDX_W-1:0]          left_index,
    input  wire logic [IDX_W-1:0]          right_index,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic [LEN_W-1:0]          n,
    output logic                           push,
    output item_t                          push_item
);

    logic [LEN_W-1:0]   left_ext;
    logic [LEN_W-1:0]   right_ext;
    logic [LEN_W-1:0]   len;
    logic [LEVEL_W-1:0] k;
    logic [LEN_W-1:0]   second;

    assign left_ext  = LEN_W'(left_index);
    assign right_ext = LEN_W'(right_index);
    assign len       = right_ext - left_ext + LEN_W'(1);
    assign k         = floor_log2(len);
    assign second    = right_ext + LEN_W'(1) - (LEN_W'(1) << k);
    assign push      = start && !full;

    always_comb
    begin
        push_item        = '0;
        push_item.lvl    = k;
        push_item.left   = left_index;
        push_item.second = second[IDX_W-1:0];
        push_item.value  = value;
        push_item.last   = (left_ext == n - LEN_W'(1));
        if (req_type == REQ_LOAD)
        begin
            push_item.kind = (left_ext >= n) ? K_LOAD_BAD : K_LOAD;
        end
        else
        begin
            push_item.kind = (left_index > right_index || right_ext >= n) ? K_QUERY_BAD
                                                                          : K_QUERY;
        end
    end

endmodule
`default_nettype wire

// File: rtl/sprm_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sprm_queue: two-entry item queue
// Decouples the classifier from the table engine.
// ---------------------------------------------------------------------------
module sprm_queue
    import sprm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output item_t      pop_item,
    output logic       full,
    output logic       empty
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/sprm_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sprm_back: table engine
// Writes loads, builds the upper levels after the last element and answers
// queries from two reads of the level table.
// ---------------------------------------------------------------------------
module sprm_back
    import sprm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [LEN_W-1:0]    n,
    input  wire logic                empty,
    input  wire item_t               head,
    output logic                     pop,
    output logic                     done,
    output logic signed [VALUE_W-1:0] max_value,
    output logic [STATUS_W-1:0]      status
);

    bk_state_t          state_reg, state_next;
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               built_reg, built_next;
    logic               wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0]  wb_addr_reg, wb_addr_next;
    logic               s1_valid_reg, s1_valid_next;
    logic [STATUS_W-1:0] s1_status_reg, s1_status_next;
    logic               s1_mem_reg, s1_mem_next;
    logic               done_reg;
    logic signed [VALUE_W-1:0] max_value_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [LEVEL_W-1:0] top;
    logic [LEN_W-1:0]   end_idx;
    logic [IDX_W-1:0]   half;
    logic [LEVEL_W-1:0] lvl_below;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr_a;
    logic [ADDR_W-1:0]  raddr_b;
    logic [VALUE_W-1:0] rdata_a;
    logic [VALUE_W-1:0] rdata_b;
    logic signed [VALUE_W-1:0] mem_max;

    assign top       = floor_log2(n);
    assign end_idx   = n - (LEN_W'(1) << lvl_reg);
    assign lvl_below = lvl_reg - LEVEL_W'(1);
    assign half      = IDX_W'(1) << lvl_below;
    assign mem_max   = smax($signed(rdata_a), $signed(rdata_b));
    assign pop       = (state_reg == BK_RUN) && !empty;

    sprm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        idx_next   = idx_reg;
        built_next = built_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                if (pop && head.kind == K_LOAD)
                begin
                    if (head.last)
                    begin
                        built_next = 1'b1;
                        if (top != '0)
                        begin
                            state_next = BK_BUILD;
                            lvl_next   = LEVEL_W'(1);
                            idx_next   = '0;
                        end
                    end
                    else
                    begin
                        built_next = 1'b0;
                    end
                end
            end
            BK_BUILD:
            begin
                if (LEN_W'(idx_reg) == end_idx)
                begin
                    state_next = BK_GAP;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            BK_GAP:
            begin
                if (lvl_reg == top)
                begin
                    state_next = BK_RUN;
                end
                else
                begin
                    state_next = BK_BUILD;
                    lvl_next   = lvl_reg + LEVEL_W'(1);
                    idx_next   = '0;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
        if (cfg_we)
        begin
            built_next = 1'b0;
        end
    end

    always_comb
    begin
        we             = 1'b0;
        waddr          = {LEVEL_W'(0), head.left};
        wdata          = head.value;
        raddr_a        = {head.lvl, head.left};
        raddr_b        = {head.lvl, head.second};
        wb_valid_next  = 1'b0;
        wb_addr_next   = {lvl_reg, idx_reg};
        s1_valid_next  = pop;
        s1_mem_next    = 1'b0;
        s1_status_next = ST_OK;

        unique case (head.kind)
            K_LOAD:      s1_status_next = ST_OK;
            K_LOAD_BAD:  s1_status_next = ST_RANGE;
            K_QUERY:     s1_status_next = built_reg ? ST_OK : ST_NOT_BUILT;
            K_QUERY_BAD: s1_status_next = built_reg ? ST_RANGE : ST_NOT_BUILT;
            default:     s1_status_next = ST_RANGE;
        endcase
        s1_mem_next = pop && head.kind == K_QUERY && built_reg;

        if (wb_valid_reg)
        begin
            we    = 1'b1;
            waddr = wb_addr_reg;
            wdata = mem_max;
        end
        else if (pop && head.kind == K_LOAD)
        begin
            we = 1'b1;
        end

        if (state_reg == BK_BUILD)
        begin
            raddr_a       = {lvl_below, idx_reg};
            raddr_b       = {lvl_below, idx_reg + half};
            wb_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg   <= wb_addr_next;
        s1_status_reg <= s1_status_next;
        status_reg    <= s1_status_reg;
        max_value_reg <= s1_mem_reg ? mem_max : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_RUN;
            lvl_reg      <= '0;
            idx_reg      <= '0;
            built_reg    <= 1'b0;
            wb_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_mem_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lvl_reg      <= lvl_next;
            idx_reg      <= idx_next;
            built_reg    <= built_next;
            wb_valid_reg <= wb_valid_next;
            s1_valid_reg <= s1_valid_next;
            s1_mem_reg   <= s1_mem_next;
            done_reg     <= s1_valid_reg;
        end
    end

    assign done      = done_reg;
    assign max_value = max_value_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_wb_not_query: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> !s1_mem_reg)
        else $error("build write-back and query share read data");

    a_gap_before_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_RUN) |-> !wb_valid_reg)
        else $error("write-back pending while serving items");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_OK) |-> (max_value_reg == '0))
        else $error("non-zero value on error result");

    a_pop_after_query_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_BUILD) |=> !s1_valid_reg)
        else $error("item taken during build");
`endif

endmodule
`default_nettype wire

// File: rtl/sparse_table_range_max_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sparse_table_range_max_unit: sparse-table range-maximum engine
// Loads elements, builds the sparse table after the last one and answers
// inclusive range-maximum queries.
//
//   channel   handshake            payload
//   request   start / busy         req_type, left_index, right_index, value
//   result    done (strobe)        max_value, status
//   config    cfg_we               cfg_wdata (array_length)
//
// One item per cycle while the queue has room; an item with nothing ahead
// of it passes through its queue entry and the s1 registers and then strobes
// done with its result. Results leave in order.
// Loading the last element starts a table build over levels p = 1 ..
// floor(log2 n), one entry per cycle on the table memory's two read ports;
// items queue behind it.
// busy rises when two items wait in the queue.
// Reset clears control state only; the table needs no clearing.
// ---------------------------------------------------------------------------
module sparse_table_range_max_unit
    import sprm_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      req_type,
    input  wire logic [IDX_W-1:0]          left_index,
    input  wire logic [IDX_W-1:0]          right_index,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                      cfg_we,
    input  wire logic [LEN_W-1:0]          cfg_wdata,
    output logic                           done,
    output logic signed [VALUE_W-1:0]      max_value,
    output logic [STATUS_W-1:0]            status
);

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             push;
    item_t            push_item;
    logic             pop;
    item_t            head;
    logic             full;
    logic             empty;

    always_comb
    begin
        priority if (cfg_wdata == '0)
        begin
            len_next = LEN_W'(1);
        end
        else if (cfg_wdata > LEN_W'(MAX_LENGTH))
        begin
            len_next = LEN_W'(MAX_LENGTH);
        end
        else
        begin
            len_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            len_reg <= len_next;
        end
    end

    assign busy = full;

    sprm_front u_front (
        .start       (start),
        .full        (full),
        .req_type    (req_type),
        .left_index  (left_index),
        .right_index (right_index),
        .value       (value),
        .n           (len_reg),
        .push        (push),
        .push_item   (push_item)
    );

    sprm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (head),
        .full      (full),
        .empty     (empty)
    );

    sprm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .n         (len_reg),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .done      (done),
        .max_value (max_value),
        .status    (status)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: sparse-table range-maximum unit testbench
// Queues load and query items for the unit, predicts each result from a
// private copy of the sparse table and the length register, and compares
// every strobed result in order. Short directed phases cover reset, the
// smallest lengths, bad indexes and rebuilds; random phases then sweep
// many lengths under varying sender gaps, ending with an over-range length.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sprm_pkg::*;

    localparam int RANDOM_ITEMS = 640;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct packed {
        logic                      req;
        logic [IDX_W-1:0]          left;
        logic [IDX_W-1:0]          right;
        logic signed [VALUE_W-1:0] value;
    } rmq_request_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] max_value;
        logic [STATUS_W-1:0]       status;
    } rmq_answer_t;

    logic                      clk;
    logic                      rst_n       = 1'b0;
    logic                      start       = 1'b0;
    logic                      req_type    = 1'b0;
    logic [IDX_W-1:0]          left_index  = '0;
    logic [IDX_W-1:0]          right_index = '0;
    logic signed [VALUE_W-1:0] value       = '0;
    logic                      cfg_we      = 1'b0;
    logic [LEN_W-1:0]          cfg_wdata   = '0;
    logic                      busy;
    logic                      done;
    logic signed [VALUE_W-1:0] max_value;
    logic [STATUS_W-1:0]       status;

    rmq_request_t queued_requests[$];
    rmq_answer_t  awaited_answers[$];

    logic signed [VALUE_W-1:0] sparse_rows [LEVELS][MAX_LENGTH];
    bit                        rows_built = 1'b0;
    logic [LEN_W-1:0]          length_reg = LEN_W'(1);

    int  gen_len = 1;
    bit  gen_written [MAX_LENGTH];
    int  queued_total = 0;
    int  gap_pct = 16;
    int  failures = 0;
    int  results_checked = 0;
    int  length_writes = 0;
    int  table_builds = 0;

    sparse_table_range_max_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .left_index  (left_index),
        .right_index (right_index),
        .value       (value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .max_value   (max_value),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int active_length(input logic [LEN_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > MAX_LENGTH)
        begin
            return MAX_LENGTH;
        end
        return int'(v);
    endfunction

    function automatic int window_level(input int span);
        int k;
        k = 0;
        while ((span >> (k + 1)) != 0)
        begin
            k++;
        end
        return (k > LEVELS - 1) ? LEVELS - 1 : k;
    endfunction

    function automatic logic signed [VALUE_W-1:0] larger(input logic signed [VALUE_W-1:0] a,
                                                        input logic signed [VALUE_W-1:0] b);
        if (b > a)
        begin
            return b;
        end
        return a;
    endfunction

    function automatic int build_cycles(input int n);
        int total;
        total = 0;
        for (int p = 1; p <= window_level(n); p++)
        begin
            total += n - (1 << p) + 2;
        end
        return total;
    endfunction

    function automatic void build_sparse_rows(input int n);
        for (int p = 1; p <= window_level(n); p++)
        begin
            for (int i = 0; i + (1 << p) <= n; i++)
            begin
                sparse_rows[p][i] = larger(sparse_rows[p-1][i], sparse_rows[p-1][i + (1 << (p-1))]);
            end
        end
    endfunction

    function automatic rmq_answer_t compute_range_max(input rmq_request_t r);
        rmq_answer_t ans;
        int n, lo, hi, k;
        ans = '0;
        n = active_length(length_reg);
        lo = r.left;
        hi = r.right;
        if (r.req == REQ_LOAD)
        begin
            if (lo >= n)
            begin
                ans.status = ST_RANGE;
            end
            else
            begin
                sparse_rows[0][lo] = r.value;
                if (lo == n - 1)
                begin
                    build_sparse_rows(n);
                    rows_built = 1'b1;
                    table_builds++;
                end
                else
                begin
                    rows_built = 1'b0;
                end
            end
        end
        else if (!rows_built)
        begin
            ans.status = ST_NOT_BUILT;
        end
        else if (lo > hi || hi >= n)
        begin
            ans.status = ST_RANGE;
        end
        else
        begin
            k = window_level(hi - lo + 1);
            ans.status = ST_OK;
            ans.max_value = larger(sparse_rows[k][lo], sparse_rows[k][hi + 1 - (1 << k)]);
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        rmq_request_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                awaited_answers.push_back(compute_range_max({req_type, left_index,
                                                             right_index, value}));
            end
            if (!start || !busy)
            begin
                if (queued_requests.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    nxt = queued_requests.pop_front();
                    start       <= 1'b1;
                    req_type    <= nxt.req;
                    left_index  <= nxt.left;
                    right_index <= nxt.right;
                    value       <= nxt.value;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        rmq_answer_t want;
        if (rst_n && done)
        begin
            if (awaited_answers.size() == 0)
            begin
                $error("unexpected result: max_value %0d status %0d", max_value, status);
                failures++;
            end
            else
            begin
                want = awaited_answers.pop_front();
                results_checked++;
                if (max_value !== want.max_value)
                begin
                    $error("max_value: expected %0d, got %0d", want.max_value, max_value);
                    failures++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    failures++;
                end
            end
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2, 3: return VALUE_W'($urandom_range(8)) - VALUE_W'(4);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_req(input logic req, input int left, input int right,
                            input logic signed [VALUE_W-1:0] v);
        queued_requests.push_back('{req, IDX_W'(left), IDX_W'(right), v});
        queued_total++;
    endtask

    task automatic push_load(input int idx, input logic signed [VALUE_W-1:0] v);
        if (idx < gen_len)
        begin
            gen_written[idx] = 1'b1;
        end
        push_req(REQ_LOAD, idx, $urandom_range(MAX_LENGTH - 1), v);
    endtask

    task automatic fill_array();
        for (int i = 0; i < gen_len; i++)
        begin
            push_load(i, pick_value());
        end
    endtask

    task automatic push_valid_query();
        int lo, hi;
        case ($urandom_range(5))
            0:
            begin
                lo = 0;
                hi = gen_len - 1;
            end
            1:
            begin
                lo = $urandom_range(gen_len - 1);
                hi = lo;
            end
            default:
            begin
                lo = $urandom_range(gen_len - 1);
                hi = $urandom_range(gen_len - 1, lo);
            end
        endcase
        push_req(REQ_QUERY, lo, hi, pick_value());
    endtask

    function automatic bit all_written();
        for (int i = 0; i < gen_len; i++)
        begin
            if (!gen_written[i])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (queued_requests.size() != 0 || start || awaited_answers.size() != 0);
        repeat (build_cycles(gen_len) + 16) @(negedge clk);
    endtask

    task automatic set_length(input int v);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= LEN_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        length_reg = LEN_W'(v);
        rows_built = 1'b0;
        gen_len    = active_length(LEN_W'(v));
        length_writes++;
    endtask

    task automatic run_random_phase(input int items);
        int base, r;
        base = queued_total;
        while (queued_total - base < items)
        begin
            r = $urandom_range(99);
            if (r < 50)
            begin
                fill_array();
                repeat ($urandom_range(12, 3)) push_valid_query();
            end
            else if (r < 62)
            begin
                if (gen_len > 1)
                begin
                    push_load($urandom_range(gen_len - 2), pick_value());
                end
                if (all_written() && $urandom_range(1))
                begin
                    push_load(gen_len - 1, pick_value());
                end
            end
            else if (r < 72)
            begin
                push_valid_query();
            end
            else if (r < 86)
            begin
                push_req(REQ_QUERY, $urandom_range(MAX_LENGTH - 1),
                         $urandom_range(MAX_LENGTH - 1), pick_value());
            end
            else if (gen_len < MAX_LENGTH)
            begin
                push_load($urandom_range(MAX_LENGTH - 1, gen_len), pick_value());
            end
        end
    endtask

    function automatic int pick_length();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return $urandom_range(160, 64);
            default: return $urandom_range(48, 3);
        endcase
    endfunction

    initial
    begin : stimulus
        int base, so_far;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct = 16;
        push_req(REQ_QUERY, 0, 0, '0);
        push_load(5, -1);
        push_load(0, VAL_MIN);
        push_req(REQ_QUERY, 0, 0, VAL_MAX);
        push_req(REQ_QUERY, 0, 1, '0);
        push_req(REQ_QUERY, 1, 0, '0);

        set_length(0);
        push_req(REQ_QUERY, 0, 0, '0);
        push_load(0, VAL_MAX);
        push_req(REQ_QUERY, 0, 0, '0);

        set_length(2);
        push_load(0, VAL_MIN);
        push_req(REQ_QUERY, 0, 1, '0);
        push_load(1, VAL_MAX);
        push_req(REQ_QUERY, 0, 1, '0);
        push_req(REQ_QUERY, 1, 1, '0);
        push_req(REQ_QUERY, 1, MAX_LENGTH - 1, '0);
        push_load(MAX_LENGTH - 1, -1);
        push_req(REQ_QUERY, 0, 0, '0);
        push_load(0, 5);
        push_req(REQ_QUERY, 0, 0, '0);
        push_load(1, -7);
        push_req(REQ_QUERY, 0, 1, '0);

        set_length(5);
        push_load(0, 3);
        push_load(1, -2);
        push_load(2, 9);
        push_load(3, 9);
        push_load(4, -100);
        push_req(REQ_QUERY, 0, 4, '0);
        push_req(REQ_QUERY, 1, 3, '0);
        push_req(REQ_QUERY, 3, 4, '0);
        push_req(REQ_QUERY, MAX_LENGTH - 1, MAX_LENGTH - 1, '0);

        base = queued_total;
        while (queued_total - base < RANDOM_ITEMS)
        begin
            set_length(pick_length());
            so_far = queued_total - base;
            gap_pct = (so_far < RANDOM_ITEMS / 3) ? 16 :
                      (so_far < 2 * RANDOM_ITEMS / 3) ? 46 : 0;
            run_random_phase($urandom_range(90, 40));
        end

        set_length((1 << LEN_W) - 1);
        gap_pct = 0;
        push_req(REQ_QUERY, 0, MAX_LENGTH - 1, '0);
        push_load(MAX_LENGTH / 2, VAL_MAX);
        push_req(REQ_QUERY, MAX_LENGTH - 1, MAX_LENGTH - 1, '1);
        push_req(REQ_QUERY, MAX_LENGTH - 1, 0, '0);

        wait_idle();
        $display("Checked %0d results from %0d items across %0d length writes, %0d table builds",
                 results_checked, queued_total, length_writes, table_builds);
        if (failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
